@@ hdl/tapv_pkg.sv @@
// ----------------------------------------------------------------------------
// tapv_pkg
// Shared constants, types and saturation helper for the three-axis PID
// velocity controller.
// ----------------------------------------------------------------------------
package tapv_pkg;

	localparam int AXES     = 3;
	localparam int FRAC     = 16;
	localparam int DATA_W   = 32;
	localparam int AXIS_W   = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int IN_W     = (2 * AXES + 1) * DATA_W;
	localparam int OUT_W    = AXES * DATA_W;
	localparam int MV_W     = 31;

	// divider numerator: 34-bit signed operand scaled up by the fraction bits
	localparam int NUM_IN_W = DATA_W + 2;
	localparam int NUM_W    = NUM_IN_W + FRAC;
	localparam int CNT_W    = $clog2(NUM_W + 1);

	// configuration register indexes
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_PGAIN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IGAIN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DGAIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_IUPPER = 3'd3;
	localparam logic [IDX_W-1:0] REG_ILOWER = 3'd4;
	localparam logic [IDX_W-1:0] REG_MAXVEL = 3'd5;

	localparam logic [MV_W-1:0] MAXVEL_RST = 31'd65536;

	typedef logic signed [DATA_W-1:0] fix_t;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	function automatic fix_t sat32(input logic signed [63:0] v);
		fix_t r;
		if (v > S32_MAX) begin
			r = fix_t'(S32_MAX[DATA_W-1:0]);
		end else if (v < S32_MIN) begin
			r = fix_t'(S32_MIN[DATA_W-1:0]);
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/tapv_mul.sv @@
// ----------------------------------------------------------------------------
// tapv_mul
// Shared fixed-point multiplier: registered 32x32 product, floor shift by the
// fraction bits and saturation to 32 bits.
// ----------------------------------------------------------------------------
module tapv_mul (
	input  logic            clk,
	input  tapv_pkg::fix_t  a,
	input  tapv_pkg::fix_t  b,
	output tapv_pkg::fix_t  y
);

	logic signed [63:0] prod_q;
	logic signed [63:0] shifted;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	// arithmetic shift rounds toward minus infinity
	assign shifted = prod_q >>> tapv_pkg::FRAC;
	assign y       = tapv_pkg::sat32(shifted);

endmodule

@@ hdl/tapv_div.sv @@
// ----------------------------------------------------------------------------
// tapv_div
// Iterative signed fixed-point divider, one quotient bit per cycle.
// Computes (num << FRAC) / den truncated toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
module tapv_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [tapv_pkg::NUM_IN_W-1:0] num,
	input  tapv_pkg::fix_t                       den,
	output logic                                 done,
	output tapv_pkg::fix_t                       quot
);

	logic [tapv_pkg::NUM_W-1:0]    quo_q;
	logic [tapv_pkg::DATA_W-1:0]   rem_q;
	logic [tapv_pkg::DATA_W-1:0]   dmag_q;
	logic                          neg_q;
	logic [tapv_pkg::CNT_W-1:0]    cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [tapv_pkg::NUM_IN_W-1:0] nmag;
	logic [tapv_pkg::DATA_W-1:0]   dmag;
	logic [tapv_pkg::DATA_W:0]     trial;
	logic                          fits;

	assign nmag  = num[tapv_pkg::NUM_IN_W-1] ? tapv_pkg::NUM_IN_W'(-num)
	                                         : tapv_pkg::NUM_IN_W'(num);
	assign dmag  = den[tapv_pkg::DATA_W-1] ? tapv_pkg::DATA_W'(-den)
	                                       : tapv_pkg::DATA_W'(den);
	assign trial = {rem_q, quo_q[tapv_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tapv_pkg::CNT_W'(tapv_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tapv_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= {nmag, {tapv_pkg::FRAC{1'b0}}};
			rem_q  <= '0;
			dmag_q <= dmag;
			neg_q  <= num[tapv_pkg::NUM_IN_W-1] ^ den[tapv_pkg::DATA_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[tapv_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? tapv_pkg::DATA_W'(trial - {1'b0, dmag_q})
			              : trial[tapv_pkg::DATA_W-1:0];
		end
	end

	// saturate the magnitude with the result sign
	always_comb begin
		if (!neg_q) begin
			if (quo_q > tapv_pkg::NUM_W'(64'h7FFF_FFFF)) begin
				quot = tapv_pkg::fix_t'(32'h7FFF_FFFF);
			end else begin
				quot = tapv_pkg::fix_t'(quo_q[tapv_pkg::DATA_W-1:0]);
			end
		end else begin
			if (quo_q > tapv_pkg::NUM_W'(64'h8000_0000)) begin
				quot = tapv_pkg::fix_t'(32'h8000_0000);
			end else begin
				quot = tapv_pkg::fix_t'(-quo_q[tapv_pkg::DATA_W-1:0]);
			end
		end
	end

	assign done = done_q;

endmodule

@@ hdl/three_axis_pid_velocity.sv @@
// ----------------------------------------------------------------------------
// three_axis_pid_velocity
// PID velocity controller for three axes with shared gains, integral clamp
// and output bound, on one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A zero time step goes straight
// to the output. Otherwise, with a nonzero integral gain, the two integral bounds
// cost two divisions first, and each axis then runs its states in order, with
// one more division when a derivative is formed; the divider, which yields one
// quotient bit per cycle, dominates the time per item. The block accepts nothing
// while an item is in work, and the result register lets the next item in
// while the last result is still waiting to be taken.
module three_axis_pid_velocity (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// goal_x, goal_y, goal_z, current_x, current_y, current_z, time_step
	input  logic [tapv_pkg::IN_W-1:0]         s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// velocity_x, velocity_y, velocity_z
	output logic [tapv_pkg::OUT_W-1:0]        m_tdata,
	// step_skipped
	output logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic [tapv_pkg::IDX_W-1:0]        cfg_index,
	input  logic [tapv_pkg::DATA_W-1:0]       cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_BLO  = 4'd1;
	localparam logic [3:0] ST_BLOW = 4'd2;
	localparam logic [3:0] ST_BHI  = 4'd3;
	localparam logic [3:0] ST_BHIW = 4'd4;
	localparam logic [3:0] ST_DER  = 4'd5;
	localparam logic [3:0] ST_DERW = 4'd6;
	localparam logic [3:0] ST_P    = 4'd7;
	localparam logic [3:0] ST_I    = 4'd8;
	localparam logic [3:0] ST_IS   = 4'd9;
	localparam logic [3:0] ST_IT   = 4'd10;
	localparam logic [3:0] ST_D    = 4'd11;
	localparam logic [3:0] ST_SUM  = 4'd12;
	localparam logic [3:0] ST_OUT  = 4'd13;

	localparam int AX = tapv_pkg::AXES;
	localparam int DW = tapv_pkg::DATA_W;

	// configuration
	tapv_pkg::fix_t                 pgain_q, igain_q, dgain_q, iupper_q, ilower_q;
	logic [tapv_pkg::MV_W-1:0]      maxvel_q;

	// per-axis state
	tapv_pkg::fix_t                 prev_err_q [AX];
	logic [AX-1:0]                  prev_valid_q;
	tapv_pkg::fix_t                 held_q     [AX];
	tapv_pkg::fix_t                 isum_q     [AX];

	// item in work
	tapv_pkg::fix_t                 goal_q [AX];
	tapv_pkg::fix_t                 cur_q  [AX];
	tapv_pkg::fix_t                 dt_q;
	tapv_pkg::fix_t                 vel_q  [AX];
	logic                           skip_q;

	logic [3:0]                     state_q;
	logic [tapv_pkg::AXIS_W-1:0]    axis_q;
	tapv_pkg::fix_t                 b0_q, lo_q, hi_q;
	tapv_pkg::fix_t                 edot_q;
	logic signed [DW+1:0]           acc_q;

	logic                           m_tvalid_q;
	logic [tapv_pkg::OUT_W-1:0]     m_tdata_q;
	logic                           m_tuser_q;

	// shared units
	tapv_pkg::fix_t                 mul_a, mul_b, mul_y;
	logic                           div_start;
	logic signed [tapv_pkg::NUM_IN_W-1:0] div_num;
	tapv_pkg::fix_t                 div_den, div_quot;
	logic                           div_done;

	tapv_pkg::fix_t                 err;
	tapv_pkg::fix_t                 isum_new, isum_clamped;
	tapv_pkg::fix_t                 it_clamped;
	tapv_pkg::fix_t                 cmd_sat;
	logic signed [DW+1:0]           cmd_bound;
	logic signed [DW+1:0]           mv_pos;
	logic                           dt_pos, in_fire, last_axis;

	tapv_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.y   (mul_y)
	);

	tapv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign dt_pos    = !dt_q[DW-1] && (dt_q != '0);
	assign last_axis = (axis_q == tapv_pkg::AXIS_W'(AX - 1));

	assign err = tapv_pkg::sat32(64'(goal_q[axis_q]) - 64'(cur_q[axis_q]));

	// operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			ST_P: begin
				mul_a = pgain_q;
				mul_b = err;
			end
			ST_I: begin
				mul_a = dt_q;
				mul_b = err;
			end
			ST_IT: begin
				mul_a = igain_q;
				mul_b = isum_q[axis_q];
			end
			ST_D: begin
				mul_a = dgain_q;
				mul_b = edot_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// operand selection for the divider
	always_comb begin
		div_start = 1'b0;
		div_num   = tapv_pkg::NUM_IN_W'(ilower_q);
		div_den   = igain_q;
		case (state_q)
			ST_BLO: begin
				div_start = 1'b1;
			end
			ST_BHI: begin
				div_start = 1'b1;
				div_num   = tapv_pkg::NUM_IN_W'(iupper_q);
			end
			ST_DER: begin
				div_start = dt_pos && prev_valid_q[axis_q];
				div_num   = tapv_pkg::NUM_IN_W'(err) -
				            tapv_pkg::NUM_IN_W'(prev_err_q[axis_q]);
				div_den   = dt_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// integral accumulation and clamp (mul_y holds dt * err in ST_IS)
	always_comb begin
		isum_new = tapv_pkg::sat32(64'(isum_q[axis_q]) + 64'(mul_y));
		isum_clamped = isum_new;
		if (igain_q != '0) begin
			if (isum_new < lo_q) begin
				isum_clamped = lo_q;
			end else if (isum_new > hi_q) begin
				isum_clamped = hi_q;
			end
		end
	end

	// integral term limits, lower limit checked first
	always_comb begin
		if (mul_y < ilower_q) begin
			it_clamped = ilower_q;
		end else if (mul_y > iupper_q) begin
			it_clamped = iupper_q;
		end else begin
			it_clamped = mul_y;
		end
	end

	assign cmd_sat = tapv_pkg::sat32(64'(acc_q) + 64'(mul_y));
	assign mv_pos  = (DW + 2)'(maxvel_q);

	always_comb begin
		if ((DW + 2)'(cmd_sat) < -mv_pos) begin
			cmd_bound = -mv_pos;
		end else if ((DW + 2)'(cmd_sat) > mv_pos) begin
			cmd_bound = mv_pos;
		end else begin
			cmd_bound = (DW + 2)'(cmd_sat);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgain_q  <= '0;
			igain_q  <= '0;
			dgain_q  <= '0;
			iupper_q <= '0;
			ilower_q <= '0;
			maxvel_q <= tapv_pkg::MAXVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tapv_pkg::REG_PGAIN:  pgain_q  <= cfg_data;
				tapv_pkg::REG_IGAIN:  igain_q  <= cfg_data;
				tapv_pkg::REG_DGAIN:  dgain_q  <= cfg_data;
				tapv_pkg::REG_IUPPER: iupper_q <= cfg_data;
				tapv_pkg::REG_ILOWER: ilower_q <= cfg_data;
				tapv_pkg::REG_MAXVEL: maxvel_q <= cfg_data[tapv_pkg::MV_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and per-axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			axis_q       <= '0;
			prev_valid_q <= '0;
			m_tvalid_q   <= 1'b0;
			for (int i = 0; i < AX; i++) begin
				prev_err_q[i] <= '0;
				held_q[i]     <= '0;
				isum_q[i]     <= '0;
			end
		end else begin
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						axis_q <= '0;
						if (s_tdata[(2 * AX + 1) * DW - 1 -: DW] == '0) begin
							state_q <= ST_OUT;
						end else if (igain_q != '0) begin
							state_q <= ST_BLO;
						end else begin
							state_q <= ST_DER;
						end
					end
				end
				ST_BLO:  state_q <= ST_BLOW;
				ST_BLOW: if (div_done) state_q <= ST_BHI;
				ST_BHI:  state_q <= ST_BHIW;
				ST_BHIW: if (div_done) state_q <= ST_DER;
				ST_DER: begin
					state_q <= div_start ? ST_DERW : ST_P;
				end
				ST_DERW: if (div_done) state_q <= ST_P;
				ST_P: begin
					held_q[axis_q] <= edot_q;
					if (dt_pos) begin
						prev_err_q[axis_q]   <= err;
						prev_valid_q[axis_q] <= 1'b1;
					end
					state_q <= ST_I;
				end
				ST_I:  state_q <= ST_IS;
				ST_IS: begin
					isum_q[axis_q] <= isum_clamped;
					state_q        <= ST_IT;
				end
				ST_IT: state_q <= ST_D;
				ST_D:  state_q <= ST_SUM;
				ST_SUM: begin
					if (last_axis) begin
						state_q <= ST_OUT;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_DER;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					for (int i = 0; i < AX; i++) begin
						goal_q[i] <= s_tdata[i * DW +: DW];
						cur_q[i]  <= s_tdata[(AX + i) * DW +: DW];
						vel_q[i]  <= '0;
					end
					dt_q   <= s_tdata[(2 * AX + 1) * DW - 1 -: DW];
					skip_q <= (s_tdata[(2 * AX + 1) * DW - 1 -: DW] == '0);
				end
			end
			ST_BLOW: if (div_done) b0_q <= div_quot;
			ST_BHIW: begin
				if (div_done) begin
					lo_q <= (b0_q < div_quot) ? b0_q : div_quot;
					hi_q <= (b0_q < div_quot) ? div_quot : b0_q;
				end
			end
			ST_DER:  if (!div_start) edot_q <= held_q[axis_q];
			ST_DERW: if (div_done) edot_q <= div_quot;
			ST_I:    acc_q <= (DW + 2)'(mul_y);
			ST_D:    acc_q <= acc_q + (DW + 2)'(it_clamped);
			ST_SUM:  vel_q[axis_q] <= cmd_bound[DW-1:0];
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					for (int i = 0; i < AX; i++) begin
						m_tdata_q[i * DW +: DW] <= vel_q[i];
					end
					m_tuser_q <= skip_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ verif/pid_velocity_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_velocity_checker
// Watches the input, output and register channels of the PID velocity
// controller, predicts every velocity command and compares field by field.
// ----------------------------------------------------------------------------
module pid_velocity_checker (
	input  logic                           clk,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [tapv_pkg::IN_W-1:0]      s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tapv_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           m_tuser,
	input  logic                           cfg_we,
	input  logic [tapv_pkg::IDX_W-1:0]     cfg_index,
	input  logic [tapv_pkg::DATA_W-1:0]    cfg_data,
	output int                             mismatches,
	output int                             pending
);

	localparam int AXES   = tapv_pkg::AXES;
	localparam int FRAC   = tapv_pkg::FRAC;
	localparam int DATA_W = tapv_pkg::DATA_W;
	localparam int IN_W   = tapv_pkg::IN_W;
	localparam int OUT_W  = tapv_pkg::OUT_W;
	localparam int MV_W   = tapv_pkg::MV_W;

	typedef struct packed {
		logic [OUT_W-1:0] vel;
		logic             skipped;
	} command_t;

	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	longint kp, ki, kd, i_upper, i_lower, vmax;
	longint prev_err [AXES];
	bit     prev_ok  [AXES];
	longint held_der [AXES];
	longint integ    [AXES];

	command_t commands_due [$];

	function automatic longint sat(input longint v);
		if (v > SMAX) begin
			return SMAX;
		end
		if (v < SMIN) begin
			return SMIN;
		end
		return v;
	endfunction

	// arithmetic shift of a signed product rounds toward minus infinity
	function automatic longint qmul(input longint a, input longint b);
		return sat((a * b) >>> FRAC);
	endfunction

	function automatic longint qdiv(input longint n, input longint d);
		return sat((n * (64'sd1 <<< FRAC)) / d);
	endfunction

	function automatic command_t pid_command(input logic [IN_W-1:0] d);
		command_t r;
		longint dt, err, edot, p, it, dd, cmd, b0, b1, lo, hi;
		dt = longint'(signed'(d[2*AXES*DATA_W +: DATA_W]));
		r.vel = '0;
		r.skipped = 1'b0;
		if (dt == 0) begin
			r.skipped = 1'b1;
			return r;
		end
		for (int a = 0; a < AXES; a++) begin
			err = sat(longint'(signed'(d[a*DATA_W +: DATA_W]))
				- longint'(signed'(d[(AXES+a)*DATA_W +: DATA_W])));
			edot = held_der[a];
			if (dt > 0) begin
				if (prev_ok[a]) begin
					edot = qdiv(err - prev_err[a], dt);
				end
				prev_err[a] = err;
				prev_ok[a] = 1'b1;
			end
			held_der[a] = edot;
			p = qmul(kp, err);
			integ[a] = sat(integ[a] + qmul(dt, err));
			if (ki != 0) begin
				b0 = qdiv(i_lower, ki);
				b1 = qdiv(i_upper, ki);
				lo = (b0 < b1) ? b0 : b1;
				hi = (b0 < b1) ? b1 : b0;
				if (integ[a] < lo) begin
					integ[a] = lo;
				end else if (integ[a] > hi) begin
					integ[a] = hi;
				end
			end
			it = qmul(ki, integ[a]);
			// lower limit is checked first, which decides the result when the limits cross
			if (it < i_lower) begin
				it = i_lower;
			end else if (it > i_upper) begin
				it = i_upper;
			end
			dd = qmul(kd, edot);
			cmd = sat(p + it + dd);
			if (cmd < -vmax) begin
				cmd = -vmax;
			end
			if (cmd > vmax) begin
				cmd = vmax;
			end
			r.vel[a*DATA_W +: DATA_W] = cmd[DATA_W-1:0];
		end
		return r;
	endfunction

	initial begin
		kp = 0;
		ki = 0;
		kd = 0;
		i_upper = 0;
		i_lower = 0;
		vmax = longint'(tapv_pkg::MAXVEL_RST);
		for (int a = 0; a < AXES; a++) begin
			prev_err[a] = 0;
			prev_ok[a] = 1'b0;
			held_der[a] = 0;
			integ[a] = 0;
		end
		mismatches = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		command_t want, got;
		bit bad;
		if (cfg_we) begin
			case (cfg_index)
				tapv_pkg::REG_PGAIN:  kp = longint'(signed'(cfg_data));
				tapv_pkg::REG_IGAIN:  ki = longint'(signed'(cfg_data));
				tapv_pkg::REG_DGAIN:  kd = longint'(signed'(cfg_data));
				tapv_pkg::REG_IUPPER: i_upper = longint'(signed'(cfg_data));
				tapv_pkg::REG_ILOWER: i_lower = longint'(signed'(cfg_data));
				tapv_pkg::REG_MAXVEL: vmax = longint'(cfg_data[MV_W-1:0]);
				default: ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			commands_due.push_back(pid_command(s_tdata));
		end
		if (m_tvalid && m_tready) begin
			got.vel = m_tdata;
			got.skipped = m_tuser;
			if (commands_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result vel=%h skipped=%b", got.vel, got.skipped);
				end
			end else begin
				want = commands_due.pop_front();
				bad = (want.skipped !== got.skipped);
				for (int a = 0; a < AXES; a++) begin
					if (want.vel[a*DATA_W +: DATA_W] !== got.vel[a*DATA_W +: DATA_W]) begin
						bad = 1'b1;
					end
				end
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected vel x/y/z %h %h %h skipped %b",
							want.vel[0 +: DATA_W], want.vel[DATA_W +: DATA_W],
							want.vel[2*DATA_W +: DATA_W], want.skipped);
						$display("          actual   vel x/y/z %h %h %h skipped %b",
							got.vel[0 +: DATA_W], got.vel[DATA_W +: DATA_W],
							got.vel[2*DATA_W +: DATA_W], got.skipped);
					end
				end
			end
		end
		pending = commands_due.size();
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the three-axis PID velocity controller: register
// settings in phases, directed corner items and bursty random steps.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int AXES   = tapv_pkg::AXES;
	localparam int DATA_W = tapv_pkg::DATA_W;
	localparam int IN_W   = tapv_pkg::IN_W;
	localparam int OUT_W  = tapv_pkg::OUT_W;
	localparam int IDX_W  = tapv_pkg::IDX_W;

	localparam int CYCLE_LIMIT = 3000000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	int                   mismatches;
	int                   pending;
	int                   cycles;
	bit                   long_hold;
	bit                   no_gaps;

	three_axis_pid_velocity i_dut (.*);

	pid_velocity_checker i_checker (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: changing stall patterns plus one long hold-off on request
	initial begin
		int mode;
		m_tready = 1'b0;
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold = 1'b0;
			end
			mode = $urandom_range(0, 3);
			for (int n = 0; n < 60; n++) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (n % 20) >= 12;
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return 32'h0;
			default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h000fffff)
				: -$urandom_range(0, 32'h000fffff);
		endcase
	endfunction

	function automatic logic [31:0] rand_step();
		case ($urandom_range(0, 11))
			0: return 32'h0;
			1: return -$urandom_range(1, 32'h00030000);
			2: return $urandom;
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(1, 32'h00030000);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] pack_step(input logic [31:0] g, input logic [31:0] c,
		input logic [31:0] dt);
		logic [IN_W-1:0] d;
		for (int a = 0; a < AXES; a++) begin
			d[a*DATA_W +: DATA_W] = g + a;
			d[(AXES+a)*DATA_W +: DATA_W] = c - a;
		end
		d[2*AXES*DATA_W +: DATA_W] = dt;
		return d;
	endfunction

	function automatic logic [IN_W-1:0] rand_item();
		logic [IN_W-1:0] d;
		for (int a = 0; a < 2 * AXES; a++) begin
			d[a*DATA_W +: DATA_W] = rand_pos();
		end
		d[2*AXES*DATA_W +: DATA_W] = rand_step();
		return d;
	endfunction

	task automatic offer(input logic [IN_W-1:0] d);
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for every command, then for the block to go idle
	task automatic drain();
		pause(1);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_gains(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
		input logic [31:0] up, input logic [31:0] lo, input logic [31:0] mv);
		write_reg(tapv_pkg::REG_PGAIN, p);
		write_reg(tapv_pkg::REG_IGAIN, i);
		write_reg(tapv_pkg::REG_DGAIN, d);
		write_reg(tapv_pkg::REG_IUPPER, up);
		write_reg(tapv_pkg::REG_ILOWER, lo);
		write_reg(tapv_pkg::REG_MAXVEL, mv & 32'h7fffffff);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_items(input int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 8);
			for (int n = 0; n < burst && count > 0; n++, count--) begin
				offer(rand_item());
			end
			if (!no_gaps && $urandom_range(0, 3) != 0) begin
				pause($urandom_range(1, 400));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		long_hold = 1'b0;
		no_gaps = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		random_items(100);
		drain();

		// moderate gains, directed corners, then random items under a long output hold-off
		set_gains(32'h00010000, 32'h00008000, 32'h00004000, 32'h000a0000, 32'hfff60000,
			32'h00640000);
		offer(pack_step(32'h00010000, 32'h0, 32'h00010000));
		offer(pack_step(32'h00020000, 32'h0, 32'h00010000));
		offer(pack_step(32'h00020000, 32'h0, 32'h0));
		offer(pack_step(32'h00030000, 32'h0, 32'hffff0000));
		offer(pack_step(32'h00050000, 32'h0, 32'hffff0000));
		offer(pack_step(32'h00040000, 32'h0, 32'h00008000));
		offer(pack_step(32'h7fffffff, 32'h80000000, 32'h00000001));
		offer(pack_step(32'h80000000, 32'h7fffffff, 32'h00000001));
		offer(pack_step(32'h7fffffff, 32'h80000000, 32'h7fffffff));
		offer(pack_step(32'h80000000, 32'h7fffffff, 32'h80000000));
		offer(pack_step(32'h0, 32'h0, 32'h7fffffff));
		offer(pack_step(32'hffffffff, 32'h00000001, 32'h00000001));
		offer(pack_step(32'h80000000, 32'h80000000, 32'h0));
		offer(pack_step(32'h12345678, 32'hedcba987, 32'h00010000));
		long_hold = 1'b1;
		random_items(250);
		drain();

		// extreme gains and widest output bound
		set_gains(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff);
		random_items(300);
		drain();

		// crossed term limits: no integral clamp and zero output bound, then both set
		set_gains(32'h00020000, 32'h0, 32'h00010000, 32'hfffe0000, 32'h00020000, 32'h0);
		random_items(150);
		drain();
		set_gains(32'h00020000, 32'h00010000, 32'h00010000, 32'hfffe0000, 32'h00020000,
			32'h00100000);
		random_items(150);
		drain();

		// random settings, one stretch without sender gaps
		no_gaps = 1'b1;
		set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		random_items(250);
		drain();
		no_gaps = 1'b0;

		// small random gains, negative and positive
		set_gains($urandom_range(0, 1) ? $urandom_range(0, 32'h00040000)
				: -$urandom_range(0, 32'h00040000),
			-$urandom_range(1, 32'h00020000), -$urandom_range(0, 32'h00020000),
			$urandom_range(0, 32'h00200000), -$urandom_range(0, 32'h00200000),
			$urandom_range(0, 32'h00800000));
		random_items(336);
		drain();

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/tapv_pkg.sv
hdl/tapv_mul.sv
hdl/tapv_div.sv
hdl/three_axis_pid_velocity.sv
verif/pid_velocity_checker.sv
verif/tb_top.sv
